FILE: src/scps_pkg.sv
`timescale 1ns / 1ps

package scps_pkg;

  // row geometry and fixed point format
  localparam int ROW_PIXELS = 96;
  localparam int FRAC_BITS  = 14;

  // field widths
  localparam int PIX_W    = 8;
  localparam int JUNC_W   = 7;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 7;
  localparam int PWM_W    = 11;
  localparam int DATA_W   = 16;
  localparam int REG_IDX_W = 3;

  // row accumulator widths
  localparam int X_W    = $clog2(ROW_PIXELS + 1);
  localparam int CNT_W  = X_W;
  localparam int SUM_W  = $clog2(ROW_PIXELS * (ROW_PIXELS - 1) / 2 + 1);
  localparam int CMP_W  = (CNT_W > JUNC_W) ? CNT_W : JUNC_W;

  // centroid divider widths
  localparam int DEN_W  = $clog2(ROW_PIXELS * ROW_PIXELS + 1);
  localparam int DIFF_W = DEN_W + 2;
  localparam int NUM_W  = DEN_W + FRAC_BITS + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // pid widths
  localparam int POS_W     = FRAC_BITS + 2;
  localparam int DERIV_W   = POS_W + 1;
  localparam int INTEG_W   = FRAC_BITS + 9;
  localparam int PROD_W    = GAIN_W + INTEG_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CTL_SHIFT = FRAC_BITS + 8;
  localparam int CTL_W     = CTL_SHIFT + 2;
  localparam int SCALED_W  = CTL_W + 7;
  localparam int STEER_W   = 8;
  localparam int SPWM_W    = PWM_W + 1;

  // constants of the control law
  localparam int LOST_W      = 4;
  localparam int LOST_LIMIT  = 10;
  localparam int LOST_MAX    = 15;
  localparam int INTEG_LIMIT = 100;
  localparam int STEER_LIMIT = 100;
  localparam int SPEED_MAX   = 100;
  localparam int PWM_CENTER  = 1500;
  localparam int PWM_STEP    = 5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_JUNCTION_COUNT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P          = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I          = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D          = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED      = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0]         pixel_threshold;
    logic [JUNC_W-1:0]        junction_count;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [SPEED_W-1:0]       base_speed;
  } cfg_t;

  // one finished row as handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             clr;
  } row_t;

endpackage

FILE: src/scps_if.sv
`timescale 1ns / 1ps

interface scps_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       row_end;
  logic       start_run;

  modport source (output valid, pixel, row_end, start_run, input ready);
  modport sink   (input valid, pixel, row_end, start_run, output ready);
endinterface

interface scps_res_if;
  logic               valid;
  logic               ready;
  logic [10:0]        throttle_pwm;
  logic [10:0]        steering_pwm;
  logic signed [15:0] line_position;
  logic               line_found;
  logic               stop_request;
  logic               end_latched_out;

  modport source (output valid, throttle_pwm, steering_pwm, line_position, line_found,
                  stop_request, end_latched_out, input ready);
  modport sink   (input valid, throttle_pwm, steering_pwm, line_position, line_found,
                  stop_request, end_latched_out, output ready);
endinterface

FILE: src/scps_front.sv
`timescale 1ns / 1ps

module scps_front import scps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  scps_pix_if.sink         pix,
  input  logic [PIX_W-1:0] threshold,
  input  logic             q_full,
  output logic             q_push,
  output row_t             q_entry
);

  logic [X_W-1:0]   x_counter;
  logic [SUM_W-1:0] position_sum;
  logic [CNT_W-1:0] lit_count;
  logic             clr_pend;

  logic [X_W-1:0]   x_counter_next;
  logic [SUM_W-1:0] position_sum_next;
  logic [CNT_W-1:0] lit_count_next;
  logic             clr_pend_next;
  logic             in_row;
  logic             lit;
  logic             accept;

  assign pix.ready = !q_full;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    in_row            = x_counter < X_W'(ROW_PIXELS);
    lit               = in_row && (pix.pixel > threshold);
    position_sum_next = lit ? position_sum + SUM_W'(x_counter) : position_sum;
    lit_count_next    = lit ? lit_count + CNT_W'(1) : lit_count;
    x_counter_next    = in_row ? x_counter + X_W'(1) : x_counter;
    // a run restart anywhere in the row applies before that row is evaluated
    clr_pend_next     = clr_pend || pix.start_run;
  end

  assign q_push  = accept && pix.row_end;
  assign q_entry = '{sum: position_sum_next, count: lit_count_next, clr: clr_pend_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_counter    <= '0;
      position_sum <= '0;
      lit_count    <= '0;
      clr_pend     <= 1'b0;
    end else if (accept) begin
      if (pix.row_end) begin
        x_counter    <= '0;
        position_sum <= '0;
        lit_count    <= '0;
        clr_pend     <= 1'b0;
      end else begin
        x_counter    <= x_counter_next;
        position_sum <= position_sum_next;
        lit_count    <= lit_count_next;
        clr_pend     <= clr_pend_next;
      end
    end
  end

endmodule

FILE: src/scps_fifo.sv
`timescale 1ns / 1ps

module scps_fifo import scps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  row_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output row_t head
);

  row_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;

  assign full      = fill == QFILL_W'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

endmodule

FILE: src/scps_div.sv
`timescale 1ns / 1ps

module scps_div import scps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  // restoring division, one quotient bit per cycle
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  den;
  logic [DCNT_W-1:0] steps;
  logic              busy;

  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    trial_sub;

  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    fits      = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
  end

  assign quotient = quo[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DCNT_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - DCNT_W'(1);
        if (steps == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: src/scps_back.sv
`timescale 1ns / 1ps

module scps_back import scps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  row_t       q_head,
  output logic       q_pop,
  scps_res_if.source res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PID   = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_CLAMP = 3'd5;
  localparam logic [2:0] ST_SCALE = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [1:0] MAC_P    = 2'd0;
  localparam logic [1:0] MAC_I    = 2'd1;
  localparam logic [1:0] MAC_D    = 2'd2;
  localparam logic [1:0] MAC_LAST = 2'd3;

  localparam logic [Q_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(INTEG_LIMIT) << FRAC_BITS;
  localparam logic signed [INTEG_W-1:0] INTEG_LO = -INTEG_HI;
  localparam logic signed [ACC_W-1:0] CTL_HI =
    {{(ACC_W - CTL_SHIFT - 1){1'b0}}, 1'b1, {CTL_SHIFT{1'b0}}};
  localparam logic signed [ACC_W-1:0] CTL_LO = -CTL_HI;
  localparam logic signed [SCALED_W-1:0] TRUNC_BIAS =
    {{(SCALED_W - CTL_SHIFT){1'b0}}, {CTL_SHIFT{1'b1}}};

  logic [2:0]                 state;
  logic [LOST_W-1:0]          lost_frames;
  logic                       end_latch;
  logic signed [INTEG_W-1:0]  error_integral;
  logic signed [POS_W-1:0]    previous_error;

  logic [SUM_W-1:0]           row_sum;
  logic [DEN_W-1:0]           den;
  logic                       neg;
  logic                       found;
  logic                       stop;
  logic signed [POS_W-1:0]    pos;
  logic signed [INTEG_W-1:0]  integ_used;
  logic signed [DERIV_W-1:0]  deriv;
  logic [1:0]                 step;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [CTL_W-1:0]    ctl_c;
  logic signed [SCALED_W-1:0] scaled;

  // row classification
  logic [LOST_W-1:0]          eff_lost;
  logic                       eff_end;
  logic [LOST_W-1:0]          lost_inc;
  logic                       junction;

  // centroid set-up
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag;
  logic [NUM_W-1:0]           dividend;
  logic                       div_start;
  logic                       div_done;
  logic [Q_W-1:0]             quotient;
  logic [Q_W-1:0]             q_clamped;

  // pid
  logic signed [INTEG_W-1:0]  integ_sum;
  logic signed [GAIN_W-1:0]   mul_a;
  logic signed [INTEG_W-1:0]  mul_b;

  // output mapping
  logic signed [SCALED_W-1:0] scaled_adj;
  logic signed [SCALED_W-1:0] steer_wide;
  logic signed [STEER_W-1:0]  steer;
  logic signed [SPWM_W-1:0]   steer_pwm;
  logic [SPEED_W-1:0]         speed;
  logic [PWM_W-1:0]           thr_pwm;
  logic                       out_free;

  always_comb begin
    eff_lost = q_head.clr ? '0 : lost_frames;
    eff_end  = q_head.clr ? 1'b0 : end_latch;
    lost_inc = (eff_lost < LOST_W'(LOST_MAX)) ? eff_lost + LOST_W'(1) : eff_lost;
    junction = CMP_W'(q_head.count) > CMP_W'(cfg.junction_count);
  end

  always_comb begin
    diff      = signed'(DIFF_W'({row_sum, 1'b0})) - signed'(DIFF_W'(den));
    mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    // rounding to nearest: half the divisor added up front
    dividend  = {mag[DEN_W-1:0], {FRAC_BITS{1'b0}}} + NUM_W'(den >> 1);
    div_start = state == ST_PREP;
    q_clamped = (quotient > ONE) ? ONE : quotient;
  end

  always_comb begin
    integ_sum = error_integral + INTEG_W'(pos);
    unique case (step)
      MAC_P: begin
        mul_a = cfg.gain_p;
        mul_b = INTEG_W'(pos);
      end
      MAC_I: begin
        mul_a = cfg.gain_i;
        mul_b = integ_used;
      end
      MAC_D: begin
        mul_a = cfg.gain_d;
        mul_b = INTEG_W'(deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    // division by a power of two that truncates toward zero
    scaled_adj = scaled + (scaled[SCALED_W-1] ? TRUNC_BIAS : '0);
    steer_wide = scaled_adj >>> CTL_SHIFT;
    steer      = steer_wide[STEER_W-1:0];
    steer_pwm  = SPWM_W'(PWM_CENTER) + SPWM_W'(steer) * SPWM_W'(PWM_STEP);
    speed      = (cfg.base_speed > SPEED_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : cfg.base_speed;
    thr_pwm    = PWM_W'(PWM_CENTER) + PWM_W'(speed) * PWM_W'(PWM_STEP);
    out_free   = !res.valid || res.ready;
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  scps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      lost_frames    <= '0;
      end_latch      <= 1'b0;
      error_integral <= '0;
      previous_error <= '0;
      res.valid      <= 1'b0;
    end else begin
      // in ST_OUT the output register is reloaded whenever it frees
      if (res.valid && res.ready && (state != ST_OUT)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.clr) begin
              error_integral <= '0;
              previous_error <= '0;
            end
            found   <= 1'b0;
            stop    <= 1'b0;
            pos     <= '0;
            row_sum <= q_head.sum;
            den     <= DEN_W'(q_head.count) * DEN_W'(ROW_PIXELS);
            priority if (q_head.count == '0) begin
              lost_frames <= lost_inc;
              if (lost_inc >= LOST_W'(LOST_LIMIT) && !eff_end) begin
                end_latch <= 1'b1;
                stop      <= 1'b1;
              end else begin
                end_latch <= eff_end;
              end
              state <= ST_PID;
            end else if (junction && !eff_end) begin
              lost_frames <= eff_lost;
              end_latch   <= 1'b1;
              stop        <= 1'b1;
              state       <= ST_PID;
            end else begin
              lost_frames <= '0;
              end_latch   <= eff_end;
              found       <= 1'b1;
              state       <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          neg   <= diff[DIFF_W-1];
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            pos   <= neg ? -POS_W'(q_clamped) : POS_W'(q_clamped);
            state <= ST_PID;
          end
        end
        ST_PID: begin
          integ_used     <= integ_sum;
          // clamped for the next row, the control term uses it unclamped
          error_integral <= (integ_sum > INTEG_HI) ? INTEG_HI :
                            (integ_sum < INTEG_LO) ? INTEG_LO : integ_sum;
          deriv          <= DERIV_W'(pos) - DERIV_W'(previous_error);
          previous_error <= pos;
          step           <= MAC_P;
          acc            <= '0;
          state          <= ST_MAC;
        end
        ST_MAC: begin
          prod <= mul_a * mul_b;
          if (step != MAC_P) begin
            acc <= acc + ACC_W'(prod);
          end
          step <= step + 2'd1;
          if (step == MAC_LAST) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          // beyond this range the steering saturates anyway
          ctl_c <= (acc > CTL_HI) ? CTL_W'(CTL_HI) :
                   (acc < CTL_LO) ? CTL_W'(CTL_LO) : acc[CTL_W-1:0];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          scaled <= SCALED_W'(ctl_c) * SCALED_W'(STEER_LIMIT);
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            res.valid           <= 1'b1;
            res.throttle_pwm    <= thr_pwm;
            res.steering_pwm    <= steer_pwm[PWM_W-1:0];
            res.line_position   <= pos;
            res.line_found      <= found;
            res.stop_request    <= stop;
            res.end_latched_out <= end_latch;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/scanline_centroid_pid_steer.sv
`timescale 1ns / 1ps

// Line follower steering from camera scan rows.
// pix channel: one grayscale pixel per request, left to right, row_end on the
// last pixel of a row, start_run to restart the run (pid, lost count, end
// latch) before that row is evaluated. Pixels past ROW_PIXELS are ignored.
// res channel: one request per row, carrying throttle and steering pulse
// widths, the Q2.14 line position and the found / stop / end flags.
// Configuration: write_en, reg_index and write_data write one register a cycle.
// Throughput: one pixel per cycle while pix.ready is high. The row
// accumulator hands each finished row to a two-entry queue; the row
// processor's time for a row with a line is dominated by the 29-step
// bit-serial centroid divider, which an empty or junction row skips.
// pix.ready drops only while the queue is full.
// Path: a row with a line goes from ST_IDLE through ST_PREP, ST_DIV, ST_PID,
// ST_MAC, ST_CLAMP and ST_SCALE to ST_OUT; an empty or junction row skips to ST_PID.
// Receiver stall: the result is held in the output register; the processor
// waits there, the queue fills, and then pix.ready drops until space frees.
// Reset (rst, synchronous): registers return to their defaults, accumulators
// and run state clear, no result is pending.
module scanline_centroid_pid_steer import scps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  scps_pix_if.sink             pix,
  scps_res_if.source           res,
  input  logic                 write_en,
  input  logic [REG_IDX_W-1:0] reg_index,
  input  logic [DATA_W-1:0]    write_data
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  row_t q_entry;
  logic q_pop;
  logic q_valid;
  row_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_threshold <= PIX_W'(128);
      cfg.junction_count  <= JUNC_W'(48);
      cfg.gain_p          <= GAIN_W'(256);
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.base_speed      <= SPEED_W'(50);
    end else if (write_en) begin
      unique case (reg_index)
        REG_PIXEL_THRESHOLD: cfg.pixel_threshold <= write_data[PIX_W-1:0];
        REG_JUNCTION_COUNT:  cfg.junction_count  <= write_data[JUNC_W-1:0];
        REG_GAIN_P:          cfg.gain_p          <= write_data[GAIN_W-1:0];
        REG_GAIN_I:          cfg.gain_i          <= write_data[GAIN_W-1:0];
        REG_GAIN_D:          cfg.gain_d          <= write_data[GAIN_W-1:0];
        REG_BASE_SPEED:      cfg.base_speed      <= write_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  scps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .threshold (cfg.pixel_threshold),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  scps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  scps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

FILE: src/scps_checker.sv
`timescale 1ns / 1ps

module scps_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [10:0]        steering_pwm,
  input logic [10:0]        throttle_pwm,
  input logic signed [15:0] line_position,
  input logic               line_found,
  input logic               stop_request,
  input logic               end_latched_out
);

  // nothing pending straight after reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(line_position) && $stable(steering_pwm))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> steering_pwm >= 11'd1000 && steering_pwm <= 11'd2000
                  && throttle_pwm >= 11'd1500 && throttle_pwm <= 11'd2000)
    else $error("pulse width out of range");

  // a stop comes only from an empty or junction row and leaves the latch set
  assert property (@(posedge clk) disable iff (rst)
    res_valid && stop_request |-> end_latched_out && !line_found)
    else $error("stop without end latch");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !line_found |-> line_position == 16'sd0)
    else $error("position without a line");

endmodule

bind scanline_centroid_pid_steer scps_checker u_scps_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .steering_pwm    (res.steering_pwm),
  .throttle_pwm    (res.throttle_pwm),
  .line_position   (res.line_position),
  .line_found      (res.line_found),
  .stop_request    (res.stop_request),
  .end_latched_out (res.end_latched_out)
);
